[sv/slcan_pkg.sv]
// ----------------------------------------------------------------------------
// slcan_pkg
// types and constants shared by the ascii can bridge
// ----------------------------------------------------------------------------
package slcan_pkg;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  host_byte;
        logic [28:0] rx_id;
        logic        rx_extended;
        logic [3:0]  rx_dlc;
        logic [63:0] rx_data;
    } slcan_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] tx_id;
        logic        tx_extended;
        logic [3:0]  tx_dlc;
        logic [63:0] tx_data;
        logic [19:0] bitrate;
        logic        last;
    } slcan_out_t;

    localparam logic [2:0] KIND_BYTE = 3'd0;
    localparam logic [2:0] KIND_TX   = 3'd1;
    localparam logic [2:0] KIND_OPEN = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_RATE = 3'd4;

    localparam logic [7:0] CH_BELL = 8'h07;
    localparam logic [7:0] CH_CR   = 8'h0D;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_ARG,
        ST_HEX_RD,
        ST_HEX_ACC,
        ST_TX_OUT,
        ST_ENC,
        ST_EMIT
    } slcan_state_t;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    function automatic logic [19:0] rate_of(input logic [3:0] s);
        logic [19:0] r;
        case (s)
            4'd0: r = 20'd10000;
            4'd1: r = 20'd20000;
            4'd2: r = 20'd50000;
            4'd3: r = 20'd100000;
            4'd4: r = 20'd125000;
            4'd5: r = 20'd250000;
            4'd6: r = 20'd500000;
            4'd7: r = 20'd800000;
            default: r = 20'd1000000;
        endcase
        return r;
    endfunction

endpackage

[sv/slcan_line_mem.sv]
// ----------------------------------------------------------------------------
// slcan_line_mem
// line buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module slcan_line_mem #(
    parameter int LINE_DEPTH = 32,
    parameter int AW = $clog2(LINE_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[sv/slcan_ascii_can_bridge.sv]
// ----------------------------------------------------------------------------
// slcan_ascii_can_bridge
// ascii serial-line can command decoder and frame encoder
// ----------------------------------------------------------------------------
// s_ channel takes one item per host byte or received can frame. m_ channel
// gives the result items of that item in order, the final one with last set.
// a host byte that is not carriage return is taken and gives no result;
// s_ready is high again on the next cycle.
// on carriage return the command character and its argument are read back
// through the single read port of the line buffer before the first result
// of a command line is given. a transmit line reads each further character
// through a read state and then an accumulate state.
// while the bridge is open, a received frame gives one ascii character per
// cycle while m_ready is high, up to 27 characters; the first one is set up
// in the encode state and then registered in the output register.
// s_ready is low while an item is at work and while a result waits on a low
// m_ready. reset clears line length, open flag and timestamp mode; buffer
// contents are not cleared. when m_ready is low the output register holds and
// the sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
module slcan_ascii_can_bridge
    import slcan_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  slcan_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output slcan_out_t m_data
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH + 1);

    slcan_state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          open_reg, open_next;
    logic          ts_reg, ts_next;
    slcan_in_t     in_reg, in_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [5:0]    pos_reg, pos_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   id_reg, id_next;
    logic [3:0]    dlc_reg, dlc_next;
    logic [63:0]   data_reg, data_next;
    logic [1:0]    phase_reg, phase_next;
    logic [4:0]    tail_reg, tail_next;
    logic [1:0]    npend_reg, npend_next;
    slcan_out_t    q0_reg, q0_next, q1_reg, q1_next;
    logic          ov_reg, ov_next;
    slcan_out_t    o_reg, o_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          out_free;
    logic [3:0]    enc_nib;
    logic [3:0]    rdlc;
    logic          ext;

    slcan_line_mem #(.LINE_DEPTH(LINE_DEPTH)) u_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(len_reg[AW-1:0]),
        .wr_data(s_data.host_byte),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = ov_reg;
    assign m_data   = o_reg;
    assign wr_en    = s_valid && s_ready && !s_data.opcode &&
                      s_data.host_byte != CH_CR && len_reg < LW'(LINE_DEPTH);
    assign rd_addr  = AW'(pos_reg);
    assign ext      = cmd_reg == 8'h54;
    assign rdlc     = (in_reg.rx_dlc > 4'd8) ? 4'd8 : in_reg.rx_dlc;

    function automatic slcan_out_t mk(input logic [2:0] k, input logic [7:0] b);
        slcan_out_t r;
        r = '0;
        r.kind = k;
        r.out_byte = b;
        return r;
    endfunction

    // encoder nibble select
    always_comb begin
        enc_nib = 4'(in_reg.rx_id >> (6'd32 - {cnt_reg[3:0], 2'b00}));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.opcode) state_next = open_reg ? ST_ENC : ST_IDLE;
                    else if (s_data.host_byte == CH_CR && len_reg != '0)
                        state_next = ST_CMD;
                end
            end
            ST_CMD:     state_next = ST_ARG;
            ST_ARG:     state_next = (phase_reg == 2'd0) ? ST_ARG : ST_EMIT;
            ST_HEX_RD:  state_next = ST_HEX_ACC;
            ST_HEX_ACC: state_next = ST_HEX_RD;
            ST_TX_OUT:  state_next = ST_EMIT;
            ST_ENC:     state_next = ST_ENC;
            ST_EMIT:    state_next = ST_EMIT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        len_next   = len_reg;
        open_next  = open_reg;
        ts_next    = ts_reg;
        in_next    = in_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        id_next    = id_reg;
        dlc_next   = dlc_reg;
        data_next  = data_reg;
        phase_next = phase_reg;
        tail_next  = tail_reg;
        npend_next = npend_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        ov_next    = ov_reg && !m_ready;
        o_next     = o_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next = s_data;
                    cnt_next = '0;
                    pos_next = '0;
                    phase_next = 2'd0;
                    if (s_data.opcode) begin
                        if (open_reg) begin
                            data_next = '0;
                            for (int k = 0; k < 8; k++) begin
                                data_next[8*k +: 8] = {s_data.rx_data[8*k +: 4],
                                                      s_data.rx_data[8*k+4 +: 4]};
                            end
                            data_next = {data_next[63:0]};
                        end
                    end else if (s_data.host_byte == CH_CR) begin
                        if (len_reg == '0) len_next = '0;
                    end else if (wr_en) begin
                        len_next = len_reg + 1'b1;
                    end
                end
            end
            ST_CMD: begin
                // rd_data is line[0]; request line[1]
                pos_next = 6'd1;
                phase_next = 2'd0;
            end
            ST_ARG: begin
                if (phase_reg == 2'd0) begin
                    if (cnt_reg == '0) begin
                        cmd_next = rd_data;
                        cnt_next = 6'd1;
                    end else begin
                        phase_next = 2'd1;
                        npend_next = 2'd1;
                        q1_next = '0;
                        q0_next = mk(KIND_BYTE, CH_CR);
                        case (cmd_reg)
                            8'h4F: if (!open_reg) begin
                                q0_next = mk(KIND_OPEN, 8'd0);
                                q1_next = mk(KIND_BYTE, CH_CR);
                                npend_next = 2'd2;
                                open_next = 1'b1;
                            end
                            8'h43: if (open_reg) begin
                                q0_next = mk(KIND_CLOSE, 8'd0);
                                q1_next = mk(KIND_BYTE, CH_CR);
                                npend_next = 2'd2;
                                open_next = 1'b0;
                            end
                            8'h53: if (len_reg >= LW'(2) && rd_data >= 8'h30 &&
                                       rd_data <= 8'h38) begin
                                q0_next = mk(KIND_RATE, 8'd0);
                                q0_next.bitrate = rate_of(4'(rd_data - 8'h30));
                                q1_next = mk(KIND_BYTE, CH_CR);
                                npend_next = 2'd2;
                            end
                            8'h5A: if (len_reg >= LW'(2)) ts_next = rd_data != 8'h30;
                            8'h74, 8'h54: begin
                                q0_next = mk(KIND_BYTE, CH_BELL);
                                if (open_reg && len_reg >= LW'(cmd_reg == 8'h54 ? 10 : 5))
                                begin
                                    phase_next = 2'd0;
                                    acc_next = '0;
                                    cnt_next = '0;
                                    pos_next = 6'd1;
                                end
                            end
                            default: q0_next = mk(KIND_BYTE, CH_BELL);
                        endcase
                    end
                end
                if (phase_reg == 2'd0 && cnt_reg != '0 &&
                    (cmd_reg == 8'h74 || cmd_reg == 8'h54) && open_reg &&
                    len_reg >= LW'(cmd_reg == 8'h54 ? 10 : 5)) begin
                    phase_next = 2'd0;
                end
            end
            ST_HEX_RD: ;
            ST_HEX_ACC: begin
                acc_next = {acc_reg[27:0], nibble_of(rd_data)};
                pos_next = pos_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (phase_reg == 2'd0 && cnt_reg == (ext ? 6'd7 : 6'd2)) begin
                    id_next = {acc_reg[27:0], nibble_of(rd_data)};
                    phase_next = 2'd1;
                    cnt_next = '0;
                end else if (phase_reg == 2'd1) begin
                    dlc_next = nibble_of(rd_data);
                    phase_next = 2'd2;
                    cnt_next = '0;
                    data_next = '0;
                end else if (phase_reg == 2'd2) begin
                    if (cnt_reg[0]) begin
                        data_next[8*cnt_reg[3:1] +: 8] = {acc_reg[3:0], nibble_of(rd_data)};
                    end
                end
            end
            ST_TX_OUT: begin
                q0_next = mk(KIND_TX, 8'd0);
                q0_next.tx_id = id_reg;
                q0_next.tx_extended = ext;
                q0_next.tx_dlc = dlc_reg;
                q0_next.tx_data = data_reg;
                q1_next = mk(KIND_BYTE, ext ? 8'h5A : 8'h7A);
                npend_next = 2'd3;
            end
            ST_ENC: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    o_next = mk(KIND_BYTE, 8'd0);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0) begin
                        o_next.out_byte = in_reg.rx_extended ? 8'h54 : 8'h74;
                        cnt_next = in_reg.rx_extended ? 6'd1 : 6'd6;
                        tail_next = 5'd0;
                    end else if (cnt_reg < 6'd9) begin
                        o_next.out_byte = hex_char(enc_nib);
                        if (cnt_reg == 6'd8) cnt_next = 6'd40;
                    end else if (cnt_reg == 6'd40) begin
                        o_next.out_byte = 8'h30 + {4'd0, rdlc};
                        cnt_next = 6'd41;
                    end else if (tail_reg < {rdlc, 1'b0}) begin
                        o_next.out_byte = hex_char(data_reg[4*tail_reg +: 4]);
                        tail_next = tail_reg + 1'b1;
                    end else begin
                        o_next.out_byte = CH_CR;
                        o_next.last = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    o_next = q0_reg;
                    o_next.last = (npend_reg == 2'd1);
                    q0_next = q1_reg;
                    q1_next = mk(KIND_BYTE, CH_CR);
                    npend_next = npend_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control sequencing beyond the simple next-state table
    slcan_state_t state_fix;
    always_comb begin
        state_fix = state_next;
        case (state_reg)
            ST_ARG: begin
                if (phase_reg == 2'd0 && cnt_reg != '0) begin
                    state_fix = ST_EMIT;
                    if ((cmd_reg == 8'h74 || cmd_reg == 8'h54) && open_reg &&
                        len_reg >= LW'(cmd_reg == 8'h54 ? 10 : 5))
                        state_fix = ST_HEX_RD;
                end else if (phase_reg == 2'd0) begin
                    state_fix = ST_ARG;
                end
            end
            ST_HEX_ACC: begin
                state_fix = ST_HEX_RD;
                if (phase_reg == 2'd1) begin
                    if (nibble_of(rd_data) > 4'd8 ||
                        len_reg < LW'({nibble_of(rd_data), 1'b0}) +
                                  LW'(ext ? 10 : 5)) begin
                        state_fix = ST_EMIT;
                    end else if (nibble_of(rd_data) == 4'd0) begin
                        state_fix = ST_TX_OUT;
                    end
                end else if (phase_reg == 2'd2 &&
                             cnt_reg == {1'b0, dlc_reg, 1'b0} - 6'd1) begin
                    state_fix = ST_TX_OUT;
                end
            end
            ST_ENC: begin
                if (out_free && cnt_reg != '0 && cnt_reg > 6'd40 &&
                    !(tail_reg < {rdlc, 1'b0}))
                    state_fix = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free && npend_reg == 2'd1) state_fix = ST_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            open_reg  <= 1'b0;
            ts_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            npend_reg <= '0;
        end else begin
            state_reg <= state_fix;
            len_reg   <= (state_fix == ST_IDLE && state_reg != ST_IDLE &&
                          !(state_reg == ST_ENC)) ? '0 : len_next;
            open_reg  <= open_next;
            ts_reg    <= ts_next;
            ov_reg    <= ov_next;
            npend_reg <= npend_next;
        end
        in_reg    <= in_next;
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        id_reg    <= id_next;
        dlc_reg   <= dlc_next;
        data_reg  <= data_next;
        phase_reg <= phase_next;
        tail_reg  <= tail_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        o_reg     <= o_next;
    end

    // timestamp mode is held for status only
    logic ts_unused;
    assign ts_unused = ts_reg;
endmodule

[sv/slcan_checker.sv]
// ----------------------------------------------------------------------------
// slcan_checker
// port level checks for the ascii can bridge
// ----------------------------------------------------------------------------
module slcan_checker
    import slcan_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input slcan_out_t m_data
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kind <= KIND_RATE)
        else $error("bad kind");

    a_byte_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_BYTE |-> m_data.tx_id == '0 && m_data.bitrate == '0)
        else $error("byte item carries request fields");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind slcan_ascii_can_bridge slcan_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
